[rtl/assert_macros.svh]
// Assertion macros used by the prime sieve RTL.
// No dependencies; the using module must have clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define PSV_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PSV_ASSERT_IMPL(lbl, ante, cons, msg)
`define PSV_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/psv_pkg.sv]
// Package for the prime sieve: widths, microcode types and the microcode ROM.
// No dependencies; used by the channel interfaces, the flag memory and the top.
`timescale 1ns / 1ps
`default_nettype none

package psv_pkg;

   localparam int MAX_LIMIT_INT = 256;
   localparam int LIM_W         = 9;
   localparam logic [LIM_W-1:0] MAX_LIMIT = LIM_W'(MAX_LIMIT_INT);
   localparam logic [LIM_W-1:0] MIN_LIMIT = LIM_W'(2);

   // Sequencer steps; the step counter holds one of these.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ERR,
      S_CLR,
      S_ITEST,
      S_ICHK,
      S_INEXT,
      S_MSTART,
      S_MARK,
      S_SINIT,
      S_SRD,
      S_SCHK,
      S_FLUSH
   } step_type;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_REQ,
      C_LT2,
      C_J_EQ_LIM,
      C_SQ_GT_LIM,
      C_FLAG,
      C_J_GT_LIM,
      C_I_GT_LIM
   } cond_type;

   typedef enum logic [1:0] {
      MEM_NONE,
      MEM_WR0,
      MEM_WR1,
      MEM_RD
   } mem_op_type;

   typedef enum logic [2:0] {
      J_HOLD,
      J_ZERO,
      J_INC,
      J_SQ,
      J_ADD_I
   } j_op_type;

   typedef enum logic [1:0] {
      I_HOLD,
      I_TWO,
      I_INC
   } i_op_type;

   typedef enum logic [1:0] {
      PUSH_NONE,
      PUSH_ERR,
      PUSH_MID,
      PUSH_LAST
   } push_type;

   // One control word of the microprogram.
   typedef struct packed {
      cond_type   cond;
      step_type   jt;
      step_type   jf;
      mem_op_type mem;
      logic       mem_if_false;  // memory op only when the branch is not taken
      logic       addr_i;        // address from i, else from j
      j_op_type   j_op;
      i_op_type   i_op;
      logic       take_pend;     // capture i as pending prime when unmarked
      push_type   push;
      logic       ld_lim;
   } ctrl_type;

   // Flag memory request between the sequencer and the store.
   typedef struct packed {
      logic             en;
      logic             wr;
      logic             wdata;
      logic [LIM_W-1:0] addr;
   } mem_req_type;

   // Microcode ROM.
   function automatic ctrl_type psv_ucode(input step_type s);
      ctrl_type c;
      c = '{cond: C_ALWAYS, jt: S_IDLE, jf: S_IDLE, mem: MEM_NONE, mem_if_false: 1'b0,
            addr_i: 1'b0, j_op: J_HOLD, i_op: I_HOLD, take_pend: 1'b0,
            push: PUSH_NONE, ld_lim: 1'b0};
      unique case (s)
         S_IDLE: begin
            c.cond   = C_REQ;
            c.jt     = S_DECODE;
            c.jf     = S_IDLE;
            c.ld_lim = 1'b1;
         end
         S_DECODE: begin
            c.cond = C_LT2;
            c.jt   = S_ERR;
            c.jf   = S_CLR;
            c.j_op = J_ZERO;
         end
         S_ERR: begin
            c.push = PUSH_ERR;
            c.jt   = S_IDLE;
            c.jf   = S_IDLE;
         end
         S_CLR: begin
            c.cond = C_J_EQ_LIM;
            c.jt   = S_ITEST;
            c.jf   = S_CLR;
            c.mem  = MEM_WR0;
            c.j_op = J_INC;
            c.i_op = I_TWO;
         end
         S_ITEST: begin
            c.cond   = C_SQ_GT_LIM;
            c.jt     = S_SINIT;
            c.jf     = S_ICHK;
            c.mem    = MEM_RD;
            c.addr_i = 1'b1;
         end
         S_ICHK: begin
            c.cond = C_FLAG;
            c.jt   = S_INEXT;
            c.jf   = S_MSTART;
         end
         S_INEXT: begin
            c.i_op = I_INC;
            c.jt   = S_ITEST;
            c.jf   = S_ITEST;
         end
         S_MSTART: begin
            c.j_op = J_SQ;
            c.jt   = S_MARK;
            c.jf   = S_MARK;
         end
         S_MARK: begin
            c.cond         = C_J_GT_LIM;
            c.jt           = S_INEXT;
            c.jf           = S_MARK;
            c.mem          = MEM_WR1;
            c.mem_if_false = 1'b1;
            c.j_op         = J_ADD_I;
         end
         S_SINIT: begin
            c.i_op = I_TWO;
            c.jt   = S_SRD;
            c.jf   = S_SRD;
         end
         S_SRD: begin
            c.cond         = C_I_GT_LIM;
            c.jt           = S_FLUSH;
            c.jf           = S_SCHK;
            c.mem          = MEM_RD;
            c.mem_if_false = 1'b1;
            c.addr_i       = 1'b1;
         end
         S_SCHK: begin
            c.take_pend = 1'b1;
            c.push      = PUSH_MID;
            c.i_op      = I_INC;
            c.jt        = S_SRD;
            c.jf        = S_SRD;
         end
         S_FLUSH: begin
            c.push = PUSH_LAST;
            c.jt   = S_IDLE;
            c.jf   = S_IDLE;
         end
         default: begin
            c.jt = S_IDLE;
            c.jf = S_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/psv_chan_if.sv]
// Valid/ready channel interfaces for the prime sieve request and response.
// Depends on psv_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface psv_req_if import psv_pkg::*;;
   logic             valid;
   logic             ready;
   logic [LIM_W-1:0] limit;

   modport source (output valid, output limit, input ready);
   modport sink   (input valid, input limit, output ready);
endinterface

interface psv_rsp_if import psv_pkg::*;;
   logic             valid;
   logic             ready;
   logic [LIM_W-1:0] prime;
   logic             last;
   logic             error;

   modport source (output valid, output prime, output last, output error, input ready);
   modport sink   (input valid, input prime, input last, input error, output ready);
endinterface

`default_nettype wire

[rtl/prime_sieve_top.sv]
// Prime sieve engine: microcoded sequencer over a one-bit composite-flag store.
// Depends on psv_pkg, psv_chan_if, psv_flag_mem and assert_macros.svh.
//
// req_chan takes one beat per request carrying an inclusive upper bound, limit;
// rsp_chan returns one beat per prime in ascending order, last set on the final
// one. A limit below 2 returns one beat with prime 0, last 1 and error 1; a limit
// above 256 is treated as 256.
// A request is taken only while the sequencer is idle. It then clears flags
// 0..limit, sieves each candidate i with i*i <= limit, marking the multiples
// of each unmarked one from i*i upward, and scans 2..limit. The single-ported
// flag store takes one access per cycle. An error request skips the clear,
// sieve and scan.
// Results pass through a one-beat output register. If a prime is ready while
// that register is still held by the receiver, hold the step and all registers
// until the beat drains. The next request is taken as soon as the last result
// sits in the output register.
// Reset: synchronous, active high; return to idle and drop the output beat and
// the pending prime. The flag store is cleared by every request with limit 2 or more.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module prime_sieve_top import psv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   psv_req_if.sink       req_chan,
   psv_rsp_if.source     rsp_chan
);

   // Step counter and current control word.
   step_type    upc_ff, upc_in;
   ctrl_type    ctrl;
   logic        cond_true;

   // Datapath registers.
   logic [LIM_W-1:0]   lim_ff, lim_in;
   logic [LIM_W-1:0]   i_ff, i_in;
   logic [LIM_W-1:0]   j_ff, j_in;
   logic [LIM_W-1:0]   pend_ff, pend_in;
   logic               pend_vld_ff, pend_vld_in;
   logic [2*LIM_W-1:0] sq;

   // Output beat register.
   logic               out_vld_ff, out_vld_in;
   logic [LIM_W-1:0]   out_prime_ff, out_prime_in;
   logic               out_last_ff, out_last_in;
   logic               out_err_ff, out_err_in;

   logic        req_fire;
   logic        out_free;
   logic        push_req;
   logic        push_fire;
   logic        stall;
   logic        rd_bit;
   mem_req_type mem_req;

   assign req_chan.ready = (upc_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !out_vld_ff || rsp_chan.ready;
   assign sq             = i_ff * i_ff;

   // Decode the control word and the branch condition.
   always_comb begin
      ctrl = psv_ucode(upc_ff);

      unique case (ctrl.cond)
         C_ALWAYS:    cond_true = 1'b1;
         C_REQ:       cond_true = req_chan.valid;
         C_LT2:       cond_true = (lim_ff < MIN_LIMIT);
         C_J_EQ_LIM:  cond_true = (j_ff == lim_ff);
         C_SQ_GT_LIM: cond_true = (sq > {{LIM_W{1'b0}}, lim_ff});
         C_FLAG:      cond_true = rd_bit;
         C_J_GT_LIM:  cond_true = (j_ff > lim_ff);
         C_I_GT_LIM:  cond_true = (i_ff > lim_ff);
         default:     cond_true = 1'b1;
      endcase

      unique case (ctrl.push)
         PUSH_NONE: push_req = 1'b0;
         PUSH_ERR:  push_req = 1'b1;
         PUSH_MID:  push_req = !rd_bit && pend_vld_ff;
         PUSH_LAST: push_req = 1'b1;
         default:   push_req = 1'b0;
      endcase

      // Hold everything while a beat is waiting for a full output register.
      stall     = push_req && !out_free;
      push_fire = push_req && !stall;

      mem_req.en    = (ctrl.mem != MEM_NONE) && !stall && !(ctrl.mem_if_false && cond_true);
      mem_req.wr    = (ctrl.mem != MEM_RD);
      mem_req.wdata = (ctrl.mem == MEM_WR1);
      mem_req.addr  = ctrl.addr_i ? i_ff : j_ff;
   end

   // Next step.
   always_comb begin
      if (stall) begin
         upc_in = upc_ff;
      end else if (cond_true) begin
         upc_in = ctrl.jt;
      end else begin
         upc_in = ctrl.jf;
      end
   end

   // Datapath updates.
   always_comb begin
      lim_in      = lim_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;

      // Saturate the bound on the way in.
      if (ctrl.ld_lim && req_fire) begin
         lim_in = (req_chan.limit > MAX_LIMIT) ? MAX_LIMIT : req_chan.limit;
      end

      if (!stall) begin
         unique case (ctrl.i_op)
            I_HOLD:  i_in = i_ff;
            I_TWO:   i_in = MIN_LIMIT;
            I_INC:   i_in = i_ff + LIM_W'(1);
            default: i_in = i_ff;
         endcase

         unique case (ctrl.j_op)
            J_HOLD:  j_in = j_ff;
            J_ZERO:  j_in = '0;
            J_INC:   j_in = j_ff + LIM_W'(1);
            J_SQ:    j_in = sq[LIM_W-1:0];
            J_ADD_I: j_in = j_ff + i_ff;
            default: j_in = j_ff;
         endcase

         if (ctrl.take_pend && !rd_bit) begin
            pend_in     = i_ff;
            pend_vld_in = 1'b1;
         end
         if (ctrl.push == PUSH_LAST) begin
            pend_vld_in = 1'b0;
         end
      end
   end

   // Output beat register: load on push, drop when taken.
   always_comb begin
      out_prime_in = out_prime_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;

      if (push_fire) begin
         out_vld_in = 1'b1;
         unique case (ctrl.push)
            PUSH_ERR: begin
               out_prime_in = '0;
               out_last_in  = 1'b1;
               out_err_in   = 1'b1;
            end
            PUSH_LAST: begin
               out_prime_in = pend_ff;
               out_last_in  = 1'b1;
               out_err_in   = 1'b0;
            end
            default: begin
               out_prime_in = pend_ff;
               out_last_in  = 1'b0;
               out_err_in   = 1'b0;
            end
         endcase
      end else if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff      <= S_IDLE;
         out_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         upc_ff      <= upc_in;
         out_vld_ff  <= out_vld_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff       <= lim_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      pend_ff      <= pend_in;
      out_prime_ff <= out_prime_in;
      out_last_ff  <= out_last_in;
      out_err_ff   <= out_err_in;
   end

   psv_flag_mem u_flag_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_bit  (rd_bit)
   );

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.prime = out_prime_ff;
   assign rsp_chan.last  = out_last_ff;
   assign rsp_chan.error = out_err_ff;

   `PSV_ASSERT_IMPL(a_mem_addr_range, mem_req.en, mem_req.addr <= MAX_LIMIT, "flag address out of range")
   `PSV_ASSERT_IMPL(a_push_room, push_fire, !out_vld_ff || rsp_chan.ready, "output beat overwritten")
   `PSV_ASSERT_NEXT(a_stall_hold, stall, upc_ff == $past(upc_ff), "step advanced during stall")
   `PSV_ASSERT_IMPL(a_flush_pend, upc_ff == S_FLUSH, pend_vld_ff, "flush without pending prime")
   `PSV_ASSERT_IMPL(a_lim_range, upc_ff == S_CLR, lim_ff >= MIN_LIMIT && lim_ff <= MAX_LIMIT, "bound out of range in sieve")

endmodule

`default_nettype wire

[rtl/psv_flag_mem.sv]
// Composite-flag store of the prime sieve: MAX_LIMIT+1 one-bit entries,
// one access per cycle, registered read data. Depends on psv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psv_flag_mem import psv_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic        rd_bit
);

   logic flags [0:MAX_LIMIT_INT];
   logic rd_bit_ff;

   always_ff @(posedge clock) begin
      if (mem_req.en && mem_req.wr) begin
         flags[mem_req.addr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.en && !mem_req.wr) begin
         rd_bit_ff <= flags[mem_req.addr];
      end
   end

   assign rd_bit = rd_bit_ff;

endmodule

`default_nettype wire
